### hdl/cmrt_pkg.sv
// shared types and constants for the multi-frame reassembly tracker
`timescale 1ns / 1ps

package cmrt_pkg;

    localparam int ID_W      = 29;
    localparam int LEN_W     = 4;
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 8;
    localparam int IDX_W     = 12;
    localparam int STATUS_W  = 4;
    localparam int SLOT_OUT_W = 3;
    localparam int OFFSET_W  = 14;
    localparam int MLEN_W    = 15;

    localparam int FRAME_BYTES = 8;
    localparam int BYTE_SHIFT  = 3;

    localparam int FIRST_BIT = 28;
    localparam int IDX_LSB   = 16;
    localparam int SRC_LSB   = 8;
    localparam int DST_LSB   = 0;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(FRAME_BYTES);

    typedef enum logic [STATUS_W-1:0] {
        ST_IGNORED     = 4'd0,
        ST_SINGLE      = 4'd1,
        ST_STARTED     = 4'd2,
        ST_APPENDED    = 4'd3,
        ST_COMPLETED   = 4'd4,
        ST_NO_SLOT     = 4'd5,
        ST_TOO_MANY    = 4'd6,
        ST_BAD_INDEX   = 4'd7,
        ST_NOT_STARTED = 4'd8
    } status_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_LOOKUP
    } fsm_t;

endpackage

### hdl/can_multiframe_reassembly_tracker.sv
// top level of the multi-frame reassembly tracker
`timescale 1ns / 1ps

// Tracks segmented messages carried in extended-id CAN frames, one result per
// frame. A frame passes the idle and lookup states: as it is accepted, the
// slot flags and source addresses are searched and the per-slot count and
// last index are read from the slot memory; in the lookup state the index
// is checked, the result is registered and the slot memory is written back.
// A frame waits in the lookup state while an earlier result has not been
// taken. The own address is written through cfg_we / cfg_wdata.

module can_multiframe_reassembly_tracker #(
    parameter int SLOTS = 5,
    parameter int MAX_PACKETS = 2048
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_we,
    input  logic [cmrt_pkg::ADDR_W-1:0]       cfg_wdata,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [cmrt_pkg::ID_W-1:0]         s_frame_id,
    input  logic [cmrt_pkg::LEN_W-1:0]        s_frame_len,
    input  logic [cmrt_pkg::DATA_W-1:0]       s_frame_data,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [cmrt_pkg::STATUS_W-1:0]     m_status,
    output logic [cmrt_pkg::SLOT_OUT_W-1:0]   m_slot,
    output logic [cmrt_pkg::ADDR_W-1:0]       m_source_addr,
    output logic [cmrt_pkg::OFFSET_W-1:0]     m_byte_offset,
    output logic [cmrt_pkg::DATA_W-1:0]       m_data_out,
    output logic [cmrt_pkg::LEN_W-1:0]        m_data_len,
    output logic [cmrt_pkg::MLEN_W-1:0]       m_message_length
);

    import cmrt_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RAM_W  = 2 * IDX_W;
    localparam logic [IDX_W-1:0] MAX_PKT = IDX_W'(MAX_PACKETS);

    fsm_t state_reg, state_next;

    logic [ADDR_W-1:0] own_addr_reg;
    logic [SLOTS-1:0]  taken_reg, taken_next;
    logic [ADDR_W-1:0] source_reg [SLOTS];

    // frame held between lookup and result
    logic              hit_dst_reg;
    logic              first_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [ADDR_W-1:0] src_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [DATA_W-1:0] data_reg;
    logic              match_found_reg, free_found_reg;
    logic [SLOT_W-1:0] match_slot_reg, free_slot_reg;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [SLOT_W-1:0]   m_slot_reg, m_slot_next;
    logic [ADDR_W-1:0]   m_src_reg, m_src_next;
    logic [OFFSET_W-1:0] m_off_reg, m_off_next;
    logic [DATA_W-1:0]   m_data_reg, m_data_next;
    logic [LEN_W-1:0]    m_len_reg, m_len_next;
    logic [MLEN_W-1:0]   m_mlen_reg, m_mlen_next;

    logic              s_xfer, out_free, finish;
    logic [ADDR_W-1:0] in_src, in_dst;
    logic [LEN_W-1:0]  in_len;
    logic              match_found, free_found;
    logic [SLOT_W-1:0] match_slot, free_slot;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [RAM_W-1:0]  ram_wdata, ram_rdata;
    logic [IDX_W-1:0]  rd_count, rd_last;
    logic              src_we;
    logic [SLOT_W-1:0] src_wslot;
    logic [DATA_W-1:0] data_masked;
    logic [MLEN_W-1:0] offset_full;
    logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

    assign s_ready  = (state_reg == FSM_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == FSM_LOOKUP) && out_free;

    assign in_src = s_frame_id[SRC_LSB +: ADDR_W];
    assign in_dst = s_frame_id[DST_LSB +: ADDR_W];
    assign in_len = (s_frame_len > MAX_LEN) ? MAX_LEN : s_frame_len;

    // lowest taken slot with this source, lowest free slot
    always_comb begin
        match_found = 1'b0;
        match_slot  = '0;
        free_found  = 1'b0;
        free_slot   = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (taken_reg[s] && source_reg[s] == in_src) begin
                match_found = 1'b1;
                match_slot  = SLOT_W'(s);
            end
            if (!taken_reg[s]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(s);
            end
        end
    end

    cmrt_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SLOTS),
        .ADDR_W(SLOT_W)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_xfer),
        .raddr (match_slot),
        .rdata (ram_rdata)
    );

    assign rd_count = ram_rdata[RAM_W-1:IDX_W];
    assign rd_last  = ram_rdata[IDX_W-1:0];
    assign offset_full = {idx_reg, BYTE_SHIFT'(0)};

    always_comb begin
        for (int i = 0; i < FRAME_BYTES; i++) begin
            data_masked[8*i +: 8] = (LEN_W'(i) < len_reg) ? data_reg[8*i +: 8] : 8'h00;
        end
    end

    always_comb begin
        state_next    = state_reg;
        taken_next    = taken_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_slot_next   = m_slot_reg;
        m_src_next    = m_src_reg;
        m_off_next    = m_off_reg;
        m_data_next   = m_data_reg;
        m_len_next    = m_len_reg;
        m_mlen_next   = m_mlen_reg;
        ram_we        = 1'b0;
        ram_waddr     = match_slot_reg;
        ram_wdata     = {rd_count, idx_reg};
        src_we        = 1'b0;
        src_wslot     = free_slot_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            FSM_IDLE: begin
                if (s_xfer) begin
                    state_next = FSM_LOOKUP;
                end
            end
            FSM_LOOKUP: begin
                if (out_free) begin
                    state_next    = FSM_IDLE;
                    m_valid_next  = 1'b1;
                    m_status_next = ST_IGNORED;
                    m_slot_next   = '0;
                    m_src_next    = '0;
                    m_off_next    = '0;
                    m_data_next   = '0;
                    m_len_next    = '0;
                    m_mlen_next   = '0;
                    if (hit_dst_reg) begin
                        m_src_next = src_reg;
                        if (first_reg) begin
                            if (idx_reg <= IDX_W'(1)) begin
                                m_status_next = ST_SINGLE;
                                m_data_next   = data_masked;
                                m_len_next    = len_reg;
                                m_mlen_next   = MLEN_W'(len_reg);
                            end else if (idx_reg > MAX_PKT) begin
                                m_status_next = ST_TOO_MANY;
                            end else if (free_found_reg) begin
                                m_status_next = ST_STARTED;
                                m_slot_next   = free_slot_reg;
                                m_data_next   = data_masked;
                                m_len_next    = len_reg;
                                m_mlen_next   = MLEN_W'(len_reg);
                                taken_next[free_slot_reg] = 1'b1;
                                src_we        = 1'b1;
                                ram_we        = 1'b1;
                                ram_waddr     = free_slot_reg;
                                ram_wdata     = {idx_reg, IDX_W'(0)};
                            end else begin
                                m_status_next = ST_NO_SLOT;
                            end
                        end else if (match_found_reg) begin
                            m_slot_next = match_slot_reg;
                            if ({1'b0, idx_reg} != {1'b0, rd_last} + (IDX_W+1)'(1)) begin
                                m_status_next = ST_BAD_INDEX;
                                taken_next[match_slot_reg] = 1'b0;
                            end else begin
                                ram_we      = 1'b1;
                                m_off_next  = offset_full[OFFSET_W-1:0];
                                m_data_next = data_masked;
                                m_len_next  = len_reg;
                                m_mlen_next = offset_full + MLEN_W'(len_reg);
                                if ({1'b0, idx_reg} + (IDX_W+1)'(1) == {1'b0, rd_count}) begin
                                    m_status_next = ST_COMPLETED;
                                    taken_next[match_slot_reg] = 1'b0;
                                end else begin
                                    m_status_next = ST_APPENDED;
                                end
                            end
                        end else begin
                            m_status_next = ST_NOT_STARTED;
                        end
                    end
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            taken_reg    <= '0;
            own_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            taken_reg   <= taken_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                own_addr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            hit_dst_reg     <= (in_dst == own_addr_reg);
            first_reg       <= s_frame_id[FIRST_BIT];
            idx_reg         <= s_frame_id[IDX_LSB +: IDX_W];
            src_reg         <= in_src;
            len_reg         <= in_len;
            data_reg        <= s_frame_data;
            match_found_reg <= match_found;
            match_slot_reg  <= match_slot;
            free_found_reg  <= free_found;
            free_slot_reg   <= free_slot;
        end
        if (src_we) begin
            source_reg[src_wslot] <= src_reg;
        end
        if (finish) begin
            m_status_reg <= m_status_next;
            m_slot_reg   <= m_slot_next;
            m_src_reg    <= m_src_next;
            m_off_reg    <= m_off_next;
            m_data_reg   <= m_data_next;
            m_len_reg    <= m_len_next;
            m_mlen_reg   <= m_mlen_next;
        end
    end

    assign slot_ext = {SLOT_OUT_W'(0), m_slot_reg};

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_slot           = slot_ext[SLOT_OUT_W-1:0];
    assign m_source_addr    = m_src_reg;
    assign m_byte_offset    = m_off_reg;
    assign m_data_out       = m_data_reg;
    assign m_data_len       = m_len_reg;
    assign m_message_length = m_mlen_reg;

endmodule

### hdl/cmrt_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module cmrt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 5,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
